[src/chs_pkg.sv]
// Shared types and constants of the cubic Hermite segment evaluator.
// No dependencies; imported by the divider and the top level.
`default_nettype none

package chs_pkg;

	// fixed field widths
	localparam int IN_W    = 32;
	localparam int RES_W   = 32;
	localparam int DIF_W   = 33;   // knot and value differences
	localparam int H2U_W   = 35;   // x_right + x_left - 2*x_eval
	localparam int PROD1_W = 66;   // 33 x 33 products
	localparam int AB_W    = 68;   // end-slope terms and their combinations
	localparam int INNER_W = 102;  // blend term of the cubic
	localparam int H3_W    = 99;   // cube of the interval width
	localparam int P2C_W   = 132;  // width-squared products
	localparam int MUL_DIG = 8;    // multiplier digit per pipeline stage

	localparam logic [RES_W-1:0] LIM_POS = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] LIM_NEG = {1'b1, {(RES_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_VALUE  = 2'd0,
		OP_FIRST  = 2'd1,
		OP_SECOND = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	// flags that ride with a beat through the divider
	typedef struct packed {
		logic zero_iv;
		logic clear;
	} div_flags_t;

endpackage

`default_nettype wire

[src/chs_mul.sv]
// Pipelined signed multiplier: one digit of the multiplier per stage.
// Carries a sideband word alongside the product. No package needed.
`default_nettype none

module chs_mul #(
	parameter int WA  = 32,
	parameter int WB  = 32,
	parameter int WS  = 1,
	parameter int DIG = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic signed [WA-1:0]  a,
	input  logic signed [WB-1:0]  b,
	input  logic [WS-1:0]         side_in,
	output logic                  out_valid,
	output logic signed [WA+WB-1:0] p,
	output logic [WS-1:0]         side_out
);

	localparam int NST = (WB + DIG - 1) / DIG;
	localparam int BW  = NST * DIG;
	localparam int PW  = WA + WB;

	logic [WB-1:0] b_abs;
	logic                 vld_s  [0:NST];
	logic signed [WA-1:0] a_s    [0:NST];
	logic [BW-1:0]        bm_s   [0:NST];
	logic                 neg_s  [0:NST];
	logic signed [PW-1:0] acc_s  [0:NST];
	logic [WS-1:0]        side_s [0:NST];
	logic                 vld_q;
	logic signed [PW-1:0] p_q;
	logic [WS-1:0]        side_q;

	// split the multiplier into sign and magnitude
	assign b_abs = b[WB-1] ? (~b + 1'b1) : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0]    <= a;
			bm_s[0]   <= BW'(b_abs);
			neg_s[0]  <= b[WB-1];
			acc_s[0]  <= '0;
			side_s[0] <= side_in;
		end
	end

	// accumulate one digit of partial product per stage
	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [DIG-1:0]         dig;
		logic signed [WA+DIG:0] pp;

		assign dig = bm_s[k][k*DIG +: DIG];
		assign pp  = a_s[k] * $signed({1'b0, dig});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k+1]    <= a_s[k];
				bm_s[k+1]   <= bm_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
				acc_s[k+1]  <= acc_s[k] + (PW'(pp) <<< (k*DIG));
			end
		end
	end

	// restore the sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q    <= neg_s[NST] ? -acc_s[NST] : acc_s[NST];
			side_q <= side_s[NST];
		end
	end

	assign out_valid = vld_q;
	assign p         = p_q;
	assign side_out  = side_q;

endmodule

`default_nettype wire

[src/chs_div.sv]
// Pipelined rounding divider with saturation to the result range.
// Depends on chs_pkg for result width, limits and flag type.
`default_nettype none

module chs_div
	import chs_pkg::*;
#(
	parameter int NW = 186,
	parameter int DW = 116
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [NW-1:0]    num,
	input  logic signed [DW-1:0]    den,
	input  div_flags_t              flags,
	output logic                    out_valid,
	output logic signed [RES_W-1:0] result,
	output logic                    zero_interval,
	output logic                    saturated
);

	localparam int RW = (NW + 2 > DW + RES_W + 1) ? NW + 2 : DW + RES_W + 1;
	localparam int NQ = RES_W;

	logic          vld_s0, vld_s1;
	logic [NW-1:0] an_s0;
	logic [DW-1:0] ad_s0;
	logic          neg_s0, neg_s1;
	div_flags_t    fl_s0, fl_s1;
	logic [RW-1:0] nn_s1, dd_s1;

	logic             vld_s [0:NQ];
	logic [RW-1:0]    rem_s [0:NQ];
	logic [RW-1:0]    dd_s  [0:NQ];
	logic [RES_W-1:0] quo_s [0:NQ];
	logic             neg_s [0:NQ];
	logic             ovf_s [0:NQ];
	div_flags_t       fl_s  [0:NQ];

	logic [RES_W-1:0] limit, mag;
	logic             sat;
	logic             vld_q, zi_q, sat_q;
	logic [RES_W-1:0] res_q;

	// magnitudes and result sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
			vld_s1 <= vld_s0;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s0  <= num[NW-1] ? NW'(-num) : NW'(num);
			ad_s0  <= den[DW-1] ? DW'(-den) : DW'(den);
			neg_s0 <= num[NW-1] ^ den[DW-1];
			fl_s0  <= flags;
			// round half away: (2n + d) / 2d
			nn_s1  <= (RW'(an_s0) << 1) + RW'(ad_s0);
			dd_s1  <= RW'(ad_s0) << 1;
			neg_s1 <= neg_s0;
			fl_s1  <= fl_s0;
			// quotient beyond the result width saturates outright
			ovf_s[0] <= nn_s1 >= (dd_s1 << RES_W);
			rem_s[0] <= nn_s1;
			dd_s[0]  <= dd_s1;
			quo_s[0] <= '0;
			neg_s[0] <= neg_s1;
			fl_s[0]  <= fl_s1;
		end
	end

	// one restoring step per stage, most significant bit first
	for (genvar j = 0; j < NQ; j++) begin : g_step
		localparam int K = NQ - 1 - j;
		logic [RW-1:0]    dsh;
		logic             ge;
		logic [RES_W-1:0] qn;

		always_comb begin
			dsh   = dd_s[j] << K;
			ge    = rem_s[j] >= dsh;
			qn    = quo_s[j];
			qn[K] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
				quo_s[j+1] <= qn;
				dd_s[j+1]  <= dd_s[j];
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
				fl_s[j+1]  <= fl_s[j];
			end
		end
	end

	// clip, apply sign, force zero on a degenerate beat
	always_comb begin
		limit = neg_s[NQ] ? LIM_NEG : LIM_POS;
		sat   = ovf_s[NQ] || (quo_s[NQ] > limit);
		mag   = sat ? limit : quo_s[NQ];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zi_q <= fl_s[NQ].zero_iv;
			if (fl_s[NQ].clear) begin
				res_q <= '0;
				sat_q <= 1'b0;
			end else begin
				res_q <= neg_s[NQ] ? (~mag + 1'b1) : mag;
				sat_q <= sat;
			end
		end
	end

	assign out_valid     = vld_q;
	assign result        = $signed(res_q);
	assign zero_interval = zi_q;
	assign saturated     = sat_q;

endmodule

`default_nettype wire

[src/cubic_hermite_segment_eval.sv]
// Top level of the cubic Hermite segment evaluator.
// Depends on chs_pkg, chs_mul and chs_div.
//
// Use: present one segment (knots, values, end slopes), an abscissa and an
// op code on the input channel; one beat comes back on the output channel
// with the value, first or second derivative in signed fixed point,
// rounded to nearest (ties away from zero) and saturated to 32 bits.
// zero_interval flags coincident knots (result 0); op 3 returns 0.
// Both channels move a beat when valid is high and stall is low.
// Throughput: one beat per cycle while out_stall does not hold the pipe.
// The path runs through three multiplier levels, one 8-bit digit per
// stage, and a restoring divider that resolves one quotient bit per stage.
// The pipeline advances as one: while a result waits under out_stall the
// whole pipe holds and in_stall rises, nothing is lost or repeated.
// Reset clears every valid bit; the pipe is empty and ready afterward.
`default_nettype none

module cubic_hermite_segment_eval
	import chs_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              op,
	input  logic signed [IN_W-1:0]  x_eval,
	input  logic signed [IN_W-1:0]  x_left,
	input  logic signed [IN_W-1:0]  x_right,
	input  logic signed [IN_W-1:0]  y_left,
	input  logic signed [IN_W-1:0]  y_right,
	input  logic signed [IN_W-1:0]  slope_left,
	input  logic signed [IN_W-1:0]  slope_right,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [RES_W-1:0] result,
	output logic                    zero_interval,
	output logic                    saturated
);

	localparam int NUM_W = 170 + FRAC_BITS;
	localparam int DEN_W = H3_W + FRAC_BITS + 1;
	localparam int P1_W  = IN_W + DIF_W;
	localparam int P2A_W = AB_W + PROD1_W;
	localparam int P3A_W = INNER_W + PROD1_W;
	localparam int P3B_W = H3_W + PROD1_W;

	typedef struct packed {
		op_t                      op;
		logic                     zero;
		logic signed [DIF_W-1:0]  h;
		logic signed [DIF_W-1:0]  u;
		logic signed [DIF_W-1:0]  hu;
		logic signed [DIF_W-1:0]  d;
		logic signed [H2U_W-1:0]  h2u;
		logic signed [IN_W-1:0]   y1;
	} side1_t;

	typedef struct packed {
		side1_t                    s;
		logic signed [PROD1_W-1:0] h2;
		logic signed [PROD1_W-1:0] uhu;
		logic signed [PROD1_W-1:0] ud;
	} mid_t;

	typedef struct packed {
		op_t                       op;
		logic                      zero;
		logic signed [H2U_W-1:0]   h2u;
		logic signed [PROD1_W-1:0] uhu;
		logic signed [IN_W-1:0]    y1;
		logic signed [AB_W-1:0]    bma;
	} side2_t;

	typedef struct packed {
		op_t                       op;
		logic                      zero;
		logic signed [H3_W-1:0]    h3;
		logic signed [P2C_W-1:0]   p2c;
		logic signed [INNER_W-1:0] inner;
	} side3_t;

	logic en;

	// stage 1: differences
	logic                   vld_s1;
	side1_t                 sd_s1;
	logic signed [IN_W-1:0] k1_s1, k2_s1;

	// level 1 products
	logic                      vld_m1;
	logic [$bits(side1_t)-1:0] side1_vec;
	logic [$bits(side1_t)-1:0] side1_vec_o;
	side1_t                    sd_m1;
	logic signed [P1_W-1:0]    k1h, k2h;
	logic signed [PROD1_W-1:0] h2, uhu, ud;

	// stages 2 to 4: slope terms
	logic                   vld_s2, vld_s3, vld_s4;
	mid_t                   md_s2, md_s3;
	logic signed [AB_W-1:0] a_s2, b_s2, a_s3, b_s3;
	logic signed [AB_W-1:0] amb_s3, bm2a_s3, bma_s3;
	logic signed [AB_W-1:0]    a2a_s4, a2b_s4;
	logic signed [PROD1_W-1:0] b2a_s4, b2b_s4, a2c_s4, b2c_s4, b2d_s4;
	side2_t                    sd2_s4;

	// level 2 products
	logic                      vld_m2;
	logic [$bits(side2_t)-1:0] side2_vec;
	side2_t                    sd_m2;
	logic signed [P2A_W-1:0]   p2a, p2b;
	logic signed [2*PROD1_W-1:0] p2c, p2d;

	// stage 5: blend term and level 3 operands
	logic                      vld_s5;
	side3_t                    sd3_s5;
	logic signed [PROD1_W-1:0] b3a_s5, b3b_s5;
	logic signed [H3_W-1:0]    a3b_s5;

	// level 3 products
	logic                      vld_m3;
	logic [$bits(side3_t)-1:0] side3_vec;
	side3_t                    sd_m3;
	logic signed [P3A_W-1:0]   p3a;
	logic signed [P3B_W-1:0]   p3b;

	// stages 6 and 7: numerator and denominator
	logic                    vld_s6, vld_s7;
	side3_t                  sd_s6;
	logic signed [NUM_W-1:0] t_s6;
	logic signed [P3A_W-1:0] p3a_s6;
	logic signed [NUM_W-1:0] num_s7;
	logic signed [DEN_W-1:0] den_s7;
	div_flags_t              fl_s7;

	// hold the whole pipe while a result waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.op   <= op_t'(op);
			sd_s1.zero <= (x_right == x_left);
			sd_s1.h    <= DIF_W'(x_right) - DIF_W'(x_left);
			sd_s1.u    <= DIF_W'(x_eval) - DIF_W'(x_left);
			sd_s1.hu   <= DIF_W'(x_right) - DIF_W'(x_eval);
			sd_s1.d    <= DIF_W'(y_right) - DIF_W'(y_left);
			sd_s1.h2u  <= H2U_W'(x_right) + H2U_W'(x_left) - (H2U_W'(x_eval) <<< 1);
			sd_s1.y1   <= y_left;
			k1_s1      <= slope_left;
			k2_s1      <= slope_right;
		end
	end

	assign side1_vec = sd_s1;
	assign sd_m1     = side1_t'(side1_vec_o);

	chs_mul #(.WA(IN_W), .WB(DIF_W), .WS($bits(side1_t)), .DIG(MUL_DIG)) u_m1a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.a(k1_s1), .b(sd_s1.h), .side_in(side1_vec),
		.out_valid(vld_m1), .p(k1h), .side_out(side1_vec_o)
	);
	chs_mul #(.WA(IN_W), .WB(DIF_W), .WS(1), .DIG(MUL_DIG)) u_m1b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.a(k2_s1), .b(sd_s1.h), .side_in(1'b0),
		.out_valid(), .p(k2h), .side_out()
	);
	chs_mul #(.WA(DIF_W), .WB(DIF_W), .WS(1), .DIG(MUL_DIG)) u_m1c (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.a(sd_s1.h), .b(sd_s1.h), .side_in(1'b0),
		.out_valid(), .p(h2), .side_out()
	);
	chs_mul #(.WA(DIF_W), .WB(DIF_W), .WS(1), .DIG(MUL_DIG)) u_m1d (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.a(sd_s1.u), .b(sd_s1.hu), .side_in(1'b0),
		.out_valid(), .p(uhu), .side_out()
	);
	chs_mul #(.WA(DIF_W), .WB(DIF_W), .WS(1), .DIG(MUL_DIG)) u_m1e (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.a(sd_s1.d), .b(sd_s1.u), .side_in(1'b0),
		.out_valid(), .p(ud), .side_out()
	);

	// stages 2 to 4: end-slope terms, then operand select per op
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_m1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			md_s2.s   <= sd_m1;
			md_s2.h2  <= h2;
			md_s2.uhu <= uhu;
			md_s2.ud  <= ud;
			a_s2 <= AB_W'(k1h) - (AB_W'(sd_m1.d) <<< FRAC_BITS);
			b_s2 <= (AB_W'(sd_m1.d) <<< FRAC_BITS) - AB_W'(k2h);

			md_s3   <= md_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			amb_s3  <= a_s2 - b_s2;
			bm2a_s3 <= b_s2 - (a_s2 <<< 1);
			bma_s3  <= b_s2 - a_s2;

			if (md_s3.s.op == OP_SECOND) begin
				a2a_s4 <= bm2a_s3;
				b2a_s4 <= PROD1_W'(md_s3.s.h);
				a2b_s4 <= amb_s3 + (amb_s3 <<< 1);
			end else begin
				a2a_s4 <= a_s3;
				b2a_s4 <= PROD1_W'(md_s3.s.hu);
				a2b_s4 <= b_s3;
			end
			b2b_s4 <= PROD1_W'(md_s3.s.u);
			a2c_s4 <= md_s3.h2;
			b2c_s4 <= (md_s3.s.op == OP_VALUE) ? md_s3.ud : PROD1_W'(md_s3.s.d);
			b2d_s4 <= PROD1_W'(md_s3.s.h);
			sd2_s4.op   <= md_s3.s.op;
			sd2_s4.zero <= md_s3.s.zero;
			sd2_s4.h2u  <= md_s3.s.h2u;
			sd2_s4.uhu  <= md_s3.uhu;
			sd2_s4.y1   <= md_s3.s.y1;
			sd2_s4.bma  <= bma_s3;
		end
	end

	logic [$bits(side2_t)-1:0] side2_vec_o;

	assign side2_vec = sd2_s4;
	assign sd_m2     = side2_t'(side2_vec_o);

	chs_mul #(.WA(AB_W), .WB(PROD1_W), .WS($bits(side2_t)), .DIG(MUL_DIG)) u_m2a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.a(a2a_s4), .b(b2a_s4), .side_in(side2_vec),
		.out_valid(vld_m2), .p(p2a), .side_out(side2_vec_o)
	);
	chs_mul #(.WA(AB_W), .WB(PROD1_W), .WS(1), .DIG(MUL_DIG)) u_m2b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.a(a2b_s4), .b(b2b_s4), .side_in(1'b0),
		.out_valid(), .p(p2b), .side_out()
	);
	chs_mul #(.WA(PROD1_W), .WB(PROD1_W), .WS(1), .DIG(MUL_DIG)) u_m2c (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.a(a2c_s4), .b(b2c_s4), .side_in(1'b0),
		.out_valid(), .p(p2c), .side_out()
	);
	chs_mul #(.WA(PROD1_W), .WB(PROD1_W), .WS(1), .DIG(MUL_DIG)) u_m2d (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.a(a2c_s4), .b(b2d_s4), .side_in(1'b0),
		.out_valid(), .p(p2d), .side_out()
	);

	// stage 5: blend term, cube of width, level 3 operand select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd3_s5.op    <= sd_m2.op;
			sd3_s5.zero  <= sd_m2.zero;
			sd3_s5.h3    <= H3_W'(p2d);
			sd3_s5.p2c   <= P2C_W'(p2c);
			sd3_s5.inner <= INNER_W'(p2a) + INNER_W'(p2b);
			if (sd_m2.op == OP_VALUE) begin
				b3a_s5 <= sd_m2.uhu;
				a3b_s5 <= H3_W'(p2d);
				b3b_s5 <= PROD1_W'(sd_m2.y1);
			end else begin
				b3a_s5 <= PROD1_W'(sd_m2.h2u);
				a3b_s5 <= H3_W'(sd_m2.bma);
				b3b_s5 <= sd_m2.uhu;
			end
		end
	end

	logic [$bits(side3_t)-1:0] side3_vec_o;

	assign side3_vec = sd3_s5;
	assign sd_m3     = side3_t'(side3_vec_o);

	chs_mul #(.WA(INNER_W), .WB(PROD1_W), .WS($bits(side3_t)), .DIG(MUL_DIG)) u_m3a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s5),
		.a(sd3_s5.inner), .b(b3a_s5), .side_in(side3_vec),
		.out_valid(vld_m3), .p(p3a), .side_out(side3_vec_o)
	);
	chs_mul #(.WA(H3_W), .WB(PROD1_W), .WS(1), .DIG(MUL_DIG)) u_m3b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s5),
		.a(a3b_s5), .b(b3b_s5), .side_in(1'b0),
		.out_valid(), .p(p3b), .side_out()
	);

	// stages 6 and 7: assemble numerator and denominator per op
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_m3;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s6  <= sd_m3;
			p3a_s6 <= p3a;
			if (sd_m3.op == OP_VALUE) begin
				t_s6 <= NUM_W'(p3b) + NUM_W'(sd_m3.p2c);
			end else begin
				t_s6 <= (NUM_W'(sd_m3.p2c) <<< FRAC_BITS) + NUM_W'(p3b);
			end

			case (sd_s6.op)
				OP_VALUE:  num_s7 <= (t_s6 <<< FRAC_BITS) + NUM_W'(p3a_s6);
				OP_FIRST:  num_s7 <= t_s6 + NUM_W'(p3a_s6);
				OP_SECOND: num_s7 <= NUM_W'(sd_s6.inner) <<< (FRAC_BITS + 1);
				default:   num_s7 <= '0;
			endcase
			if (sd_s6.op == OP_VALUE) begin
				den_s7 <= DEN_W'(sd_s6.h3) <<< FRAC_BITS;
			end else begin
				den_s7 <= DEN_W'(sd_s6.h3);
			end
			fl_s7.zero_iv <= sd_s6.zero;
			fl_s7.clear   <= sd_s6.zero || (sd_s6.op == OP_UNUSED);
		end
	end

	chs_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s7),
		.num(num_s7), .den(den_s7), .flags(fl_s7),
		.out_valid(out_valid), .result(result),
		.zero_interval(zero_interval), .saturated(saturated)
	);

endmodule

`default_nettype wire
